// ===== rtl/uks_pkg.sv =====
package uks_pkg;

    // Command codes carried by a word on the command port
    localparam logic [2:0] CMD_PUSH   = 3'd0;
    localparam logic [2:0] CMD_POP    = 3'd1;
    localparam logic [2:0] CMD_PEEK   = 3'd2;
    localparam logic [2:0] CMD_CLEAR  = 3'd3;
    localparam logic [2:0] CMD_REPORT = 3'd4;

    localparam int unsigned KEY_W    = 32;
    localparam int unsigned DEPTH_W  = 8;
    localparam int unsigned COUNT_W  = 32;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_DUP   = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

endpackage

// ===== rtl/unique_key_stack.sv =====
// unique_key_stack: a bounded stack of signed 32-bit keys that refuses a
// push of a key already stored. A command word is taken when start is high
// and busy is low; its single result appears on the result ports for exactly
// one cycle with done high, and cannot be held off. depth and served_count
// show the state after the step during that cycle. A push walks the
// stored entries for the duplicate check, reading them from one
// single-port-read memory, one entry per cycle, through one shared
// comparator; pop and peek read the top, report reads the top, then the
// base; clear, a push to a full stack, pop/peek/report on an empty stack
// and unknown commands are answered without leaving the idle state.
// A new command may be given in the cycle that done is high.
module unique_key_stack
    import uks_pkg::*;
#(
    parameter int unsigned DEPTH = 128
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [2:0]                command,
    input  logic signed [KEY_W-1:0]   key_in,
    output logic                      done,
    output logic [1:0]                status,
    output logic signed [KEY_W-1:0]   top_key,
    output logic signed [KEY_W-1:0]   base_key,
    output logic [DEPTH_W-1:0]        depth,
    output logic [COUNT_W-1:0]        served_count
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TOP_WAIT,
        S_BASE_WAIT
    } state_t;

    state_t               state_reg, state_next;
    logic [2:0]           cmd_reg, cmd_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic                 pend_reg, pend_next;
    logic [CW-1:0]        fill_reg, fill_next;
    logic [COUNT_W-1:0]   served_reg, served_next;
    logic                 done_reg, done_next;
    status_t              status_reg, status_next;
    logic [KEY_W-1:0]     top_reg, top_next;
    logic [KEY_W-1:0]     base_reg, base_next;

    logic                 accept;
    logic                 empty;
    logic                 full;
    logic                 issue;
    logic                 match;
    logic [CW-1:0]        fill_m1;
    logic                 ram_we;
    logic [AW-1:0]        ram_raddr;
    logic [KEY_W-1:0]     ram_rdata;

    assign accept  = start && (state_reg == S_IDLE);
    assign empty   = (fill_reg == '0);
    assign full    = (fill_reg == CW'(DEPTH));
    assign fill_m1 = fill_reg - CW'(1);
    assign issue   = (idx_reg < fill_reg);
    // Shared comparator: stored word against the pushed key
    assign match   = pend_reg && (ram_rdata == key_reg);

    // Select the read address: top on accept, scan index, base for report
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:     ram_raddr = fill_m1[AW-1:0];
            S_SCAN:     ram_raddr = idx_reg[AW-1:0];
            default:    ram_raddr = '0;
        endcase
    end

    assign ram_we = (state_reg == S_SCAN) && !match && !issue && !pend_reg;

    uks_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (key_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer: decode on accept, walk entries for push, collect reads
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        pend_next   = 1'b0;
        fill_next   = fill_reg;
        served_next = served_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        top_next    = top_reg;
        base_next   = base_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = command;
                    key_next    = key_in;
                    idx_next    = '0;
                    status_next = ST_OK;
                    top_next    = '0;
                    base_next   = '0;
                    case (command)
                        CMD_PUSH:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        CMD_POP, CMD_PEEK, CMD_REPORT:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_TOP_WAIT;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            fill_next = '0;
                            done_next = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (match)
                begin
                    status_next = ST_DUP;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (issue)
                begin
                    idx_next  = idx_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                begin
                    // no duplicate: store at the top
                    fill_next  = fill_reg + CW'(1);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_TOP_WAIT:
            begin
                top_next = ram_rdata;
                if (cmd_reg == CMD_REPORT)
                begin
                    state_next = S_BASE_WAIT;
                end
                else
                begin
                    if (cmd_reg == CMD_POP)
                    begin
                        fill_next = fill_m1;
                        if (served_reg != '1)
                        begin
                            served_next = served_reg + COUNT_W'(1);
                        end
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_BASE_WAIT:
            begin
                base_next   = ram_rdata;
                status_next = full ? ST_FULL : ST_OK;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state and the strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pend_reg   <= 1'b0;
            fill_reg   <= '0;
            served_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pend_reg   <= pend_next;
            fill_reg   <= fill_next;
            served_reg <= served_next;
            done_reg   <= done_next;
        end
    end

    // Hold the command word and result payload
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        top_reg    <= top_next;
        base_reg   <= base_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign top_key      = top_reg;
    assign base_key     = base_reg;
    assign depth        = DEPTH_W'(fill_reg);
    assign served_count = served_reg;

endmodule

// ===== rtl/uks_ram.sv =====
module uks_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 128
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/uks_checker.sv =====
module uks_checker
    import uks_pkg::*;
#(
    parameter int unsigned DEPTH = 128
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic [2:0]                command,
    input  logic signed [KEY_W-1:0]   key_in,
    input  logic                      done,
    input  logic [1:0]                status,
    input  logic signed [KEY_W-1:0]   top_key,
    input  logic signed [KEY_W-1:0]   base_key,
    input  logic [DEPTH_W-1:0]        depth,
    input  logic [COUNT_W-1:0]        served_count
);

    // An accepted word is either still in work or finished next cycle
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted word neither in work nor finished");

    // A result is shown only once the sequencer is back at rest
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // An empty result reports no stored entries and zero keys
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_EMPTY |-> depth == '0 && top_key == '0 && base_key == '0)
        else $error("empty status with stored entries or keys");

    // A full result reports the stack at capacity
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_FULL |-> depth == DEPTH_W'(DEPTH))
        else $error("full status below capacity");

endmodule

bind unique_key_stack uks_checker #(.DEPTH(DEPTH)) u_uks_checker (.*);

// ===== test/unique_key_stack_checker.sv =====
`timescale 1ns / 100ps
module unique_key_stack_checker
    import uks_pkg::*;
#(
    parameter int unsigned DEPTH = 128
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic [2:0]                command,
    input  logic signed [KEY_W-1:0]   key_in,
    input  logic                      done,
    input  logic [1:0]                status,
    input  logic signed [KEY_W-1:0]   top_key,
    input  logic signed [KEY_W-1:0]   base_key,
    input  logic [DEPTH_W-1:0]        depth,
    input  logic [COUNT_W-1:0]        served_count,
    output int                        errors,
    output int                        outstanding
);

    typedef struct {
        status_t                 status;
        logic signed [KEY_W-1:0] top;
        logic signed [KEY_W-1:0] base;
        logic [DEPTH_W-1:0]      depth;
        logic [COUNT_W-1:0]      served;
    } stack_result_t;

    // Shadow of the stack contents and counters
    logic signed [KEY_W-1:0] stored_keys [DEPTH];
    int unsigned             fill;
    logic [COUNT_W-1:0]      pops_served;
    stack_result_t           results_due [$];

    initial
    begin
        errors = 0;
        outstanding = 0;
    end

    // Apply one command word to the shadow stack and return its result
    function automatic stack_result_t step_stack(input logic [2:0] cmd,
                                                 input logic signed [KEY_W-1:0] key);
        stack_result_t r;
        bit            seen;
        r.status = ST_OK;
        r.top    = '0;
        r.base   = '0;
        seen     = 1'b0;
        case (cmd)
            CMD_PUSH:
            begin
                if (fill >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    for (int i = 0; i < fill; i++)
                        if (stored_keys[i] == key)
                            seen = 1'b1;
                    if (seen)
                        r.status = ST_DUP;
                    else
                    begin
                        stored_keys[fill] = key;
                        fill++;
                    end
                end
            end
            CMD_POP:
            begin
                if (fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    fill--;
                    r.top = stored_keys[fill];
                    // hold the counter once it saturates
                    if (pops_served != '1)
                        pops_served++;
                end
            end
            CMD_PEEK:
            begin
                if (fill == 0)
                    r.status = ST_EMPTY;
                else
                    r.top = stored_keys[fill - 1];
            end
            CMD_CLEAR:
                fill = 0;
            CMD_REPORT:
            begin
                if (fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.top  = stored_keys[fill - 1];
                    r.base = stored_keys[0];
                    if (fill >= DEPTH)
                        r.status = ST_FULL;
                end
            end
            default:
                ;
        endcase
        r.depth  = DEPTH_W'(fill);
        r.served = pops_served;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %h got %h", $time, field, want, got);
            errors++;
        end
    endtask

    // Compare the result word first, then predict the newly accepted word
    always @(posedge clk or negedge rst_n)
    begin : watch
        stack_result_t due;
        if (!rst_n)
        begin
            fill = 0;
            pops_served = '0;
            results_due.delete();
            outstanding = 0;
        end
        else
        begin
            if (done)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t ns: result word with none expected, got status %h",
                             $time, status);
                    errors++;
                end
                else
                begin
                    due = results_due.pop_front();
                    check_field("status", COUNT_W'(due.status), COUNT_W'(status));
                    check_field("top_key", due.top, top_key);
                    check_field("base_key", due.base, base_key);
                    check_field("depth", COUNT_W'(due.depth), COUNT_W'(depth));
                    check_field("served_count", due.served, served_count);
                end
            end
            if (start && !busy)
                results_due.push_back(step_stack(command, key_in));
            outstanding = results_due.size();
        end
    end

endmodule

// ===== test/unique_key_stack_tb.sv =====
`timescale 1ns / 100ps
module unique_key_stack_tb;
    import uks_pkg::*;

    localparam int unsigned DEPTH       = 128;
    localparam int          WORD_COUNT  = 1400;
    localparam int          QUIET_TAIL  = 150;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          CMD_CODES   = 8;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic [2:0]              command = CMD_PUSH;
    logic signed [KEY_W-1:0] key_in = '0;
    logic                    busy;
    logic                    done;
    logic [1:0]              status;
    logic signed [KEY_W-1:0] top_key;
    logic signed [KEY_W-1:0] base_key;
    logic [DEPTH_W-1:0]      depth;
    logic [COUNT_W-1:0]      served_count;
    int                      errors;
    int                      outstanding;

    int                      words_sent = 0;
    int                      calm_left = 0;
    int                      cycles = 0;
    logic signed [KEY_W-1:0] key_history [$];

    unique_key_stack #(.DEPTH(DEPTH)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .key_in(key_in), .done(done), .status(status),
        .top_key(top_key), .base_key(base_key), .depth(depth),
        .served_count(served_count)
    );

    unique_key_stack_checker #(.DEPTH(DEPTH)) stack_check (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .key_in(key_in), .done(done), .status(status),
        .top_key(top_key), .base_key(base_key), .depth(depth),
        .served_count(served_count), .errors(errors), .outstanding(outstanding)
    );

    always #2 clk = ~clk;

    // Abandon a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offer one word and hold it until the block takes it
    task automatic send_word(input logic [2:0] cmd, input logic signed [KEY_W-1:0] key);
        start   <= 1'b1;
        command <= cmd;
        key_in  <= key;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
        if (cmd == CMD_PUSH)
        begin
            key_history.push_back(key);
            if (key_history.size() > 16)
                void'(key_history.pop_front());
        end
    endtask

    task automatic rest(input int n);
        start <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Idle in short bursts, with calm stretches, and never in the tail
    task automatic pace();
        if (words_sent >= WORD_COUNT - QUIET_TAIL)
            return;
        if (calm_left > 0)
            calm_left--;
        else if ($urandom_range(0, 19) == 0)
            calm_left = $urandom_range(20, 60);
        else if ($urandom_range(0, 2) == 0)
            rest($urandom_range(1, 6));
    endtask

    // Hold off until every outstanding result has come back
    task automatic drain();
        start <= 1'b0;
        wait (outstanding == 0);
        @(negedge clk);
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key();
        int kind;
        kind = $urandom_range(0, 3);
        case (kind)
            0: return $urandom;
            1: return int'($urandom_range(0, 16)) - 8;
            2:
            begin
                if (key_history.size() == 0)
                    return $urandom;
                return key_history[$urandom_range(0, key_history.size() - 1)];
            end
            default:
            begin
                case ($urandom_range(0, 3))
                    0: return KEY_MIN;
                    1: return KEY_MAX;
                    2: return 0;
                    default: return -1;
                endcase
            end
        endcase
    endfunction

    // Fill the stack to capacity, push past it, then unwind part way or fully
    task automatic fill_to_capacity();
        send_word(CMD_CLEAR, $urandom);
        repeat (DEPTH + 3)
        begin
            pace();
            send_word(CMD_PUSH, $urandom);
        end
        send_word(CMD_PUSH, key_history[$urandom_range(0, key_history.size() - 1)]);
        send_word(CMD_REPORT, $urandom);
        send_word(CMD_PEEK, $urandom);
        repeat ($urandom_range(1, DEPTH))
        begin
            pace();
            send_word(CMD_POP, $urandom);
        end
        send_word(CMD_REPORT, $urandom);
    endtask

    // Weighted mix of commands with keys that often collide
    task automatic mixed_traffic(input int until_count);
        int roll;
        while (words_sent < until_count)
        begin
            pace();
            roll = $urandom_range(0, 99);
            if (roll < 45)
                send_word(CMD_PUSH, pick_key());
            else if (roll < 65)
                send_word(CMD_POP, $urandom);
            else if (roll < 75)
                send_word(CMD_PEEK, $urandom);
            else if (roll < 77)
                send_word(CMD_CLEAR, $urandom);
            else if (roll < 94)
                send_word(CMD_REPORT, $urandom);
            else
                send_word(3'($urandom_range(CMD_REPORT + 1, CMD_CODES - 1)), $urandom);
        end
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty stack, extreme keys, duplicates, unused codes, clear
        send_word(CMD_POP, 0);
        send_word(CMD_PEEK, 0);
        send_word(CMD_REPORT, 0);
        send_word(CMD_PUSH, KEY_MIN);
        send_word(CMD_PUSH, KEY_MAX);
        send_word(CMD_PUSH, 0);
        send_word(CMD_PUSH, -1);
        send_word(CMD_PUSH, KEY_MAX);
        send_word(CMD_PUSH, KEY_MIN);
        send_word(CMD_REPORT, 0);
        send_word(CMD_PEEK, 0);
        send_word(CMD_POP, 0);
        send_word(CMD_POP, 0);
        for (int c = CMD_REPORT + 1; c < CMD_CODES; c++)
            send_word(3'(c), -1);
        send_word(CMD_CLEAR, 0);
        send_word(CMD_REPORT, 0);
        send_word(CMD_POP, 0);
        send_word(CMD_PUSH, 32'sh5a5a_a5a5);
        send_word(CMD_PUSH, ~32'sh5a5a_a5a5);
        send_word(CMD_REPORT, 0);
        send_word(CMD_CLEAR, 0);
        drain();

        fill_to_capacity();
        drain();
        mixed_traffic(700);
        fill_to_capacity();
        drain();
        mixed_traffic(WORD_COUNT);

        // Let the last results land
        start <= 1'b0;
        wait (outstanding == 0);
        repeat (DEPTH + 4) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
